FILE: rtl/fir_sat_pkg.sv
// Shared constants and controller/datapath interface types for the saturating FIR filter.
package fir_sat_pkg;

   localparam int MAX_TAPS   = 512;
   localparam int HIST_DEPTH = MAX_TAPS - 1;
   localparam int ADDR_W     = $clog2(MAX_TAPS);
   localparam int TAP_W      = $clog2(MAX_TAPS + 1);
   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 20;
   localparam int FRAC_BITS  = 16;
   localparam int PROD_W     = SAMPLE_W + COEF_W;
   localparam int ACC_W      = PROD_W + ADDR_W + 3;
   localparam int Q_W        = ACC_W - FRAC_BITS + 1;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLED = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAPS    = 1'd1;

   localparam logic [TAP_W-1:0] TAPS_RESET = TAP_W'(128);
   localparam logic [TAP_W-1:0] TAPS_MIN   = TAP_W'(2);
   localparam logic [TAP_W-1:0] TAPS_MAX   = TAP_W'(MAX_TAPS);

   localparam logic MODE_FILTER = 1'b0;
   localparam logic MODE_LOAD   = 1'b1;

   typedef struct packed {
      logic capture;
      logic start;
      logic issue;
      logic coef_write;
      logic hist_clear;
      logic round;
      logic hist_push;
      logic out_load;
      logic pass;
   } cmd_type;

   typedef struct packed {
      logic last_tap;
      logic enabled;
      logic out_free;
   } status_type;

endpackage

FILE: rtl/fir_sat_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fir_sat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/fir_sat_ctrl.sv
// Sequencer for the FIR filter: accepts words and steps the datapath through each sample.
module fir_sat_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_mode,
   input  fir_sat_pkg::status_type status,
   output fir_sat_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_ROUND,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;
   logic      drain_ff, drain_in;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in       = state_ff;
      pass_in        = pass_ff;
      drain_in       = drain_ff;
      cmd            = '0;
      cmd.pass       = pass_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_mode == fir_sat_pkg::MODE_LOAD) begin
                  cmd.coef_write = 1'b1;
                  cmd.hist_clear = 1'b1;
               end else if (status.enabled) begin
                  cmd.capture = 1'b1;
                  cmd.start   = 1'b1;
                  pass_in     = 1'b0;
                  state_in    = ST_RUN;
               end else begin
                  cmd.capture = 1'b1;
                  pass_in     = 1'b1;
                  state_in    = ST_EMIT;
               end
            end
         end
         ST_RUN: begin
            cmd.issue = 1'b1;
            if (status.last_tap) begin
               drain_in = 1'b1;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            drain_in = 1'b0;
            if (!drain_ff) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round     = 1'b1;
            cmd.hist_push = 1'b1;
            state_in      = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
         drain_ff <= drain_in;
      end
   end

endmodule

FILE: rtl/fir_sat_dp.sv
// FIR datapath: coefficient and history RAMs, shared multiply-accumulate, rounding, output word.
module fir_sat_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [fir_sat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fir_sat_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic signed [fir_sat_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [fir_sat_pkg::ADDR_W-1:0]          req_coef_index,
   input  logic signed [fir_sat_pkg::COEF_W-1:0]   req_coef_value,
   input  fir_sat_pkg::cmd_type                    cmd,
   output fir_sat_pkg::status_type                 status,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [fir_sat_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                    rsp_clipped
);

   localparam int AW = fir_sat_pkg::ADDR_W;
   localparam int TW = fir_sat_pkg::TAP_W;
   localparam int SW = fir_sat_pkg::SAMPLE_W;
   localparam int CW = fir_sat_pkg::COEF_W;
   localparam int PW = fir_sat_pkg::PROD_W;
   localparam int ACW = fir_sat_pkg::ACC_W;
   localparam int QW = fir_sat_pkg::Q_W;
   localparam int FB = fir_sat_pkg::FRAC_BITS;
   localparam logic [AW-1:0] HIST_LAST = AW'(fir_sat_pkg::HIST_DEPTH - 1);
   localparam logic [AW-1:0] FILL_MAX  = AW'(fir_sat_pkg::HIST_DEPTH);
   localparam logic signed [QW-1:0] SAT_HI = QW'((1 << (SW - 1)) - 1);
   localparam logic signed [QW-1:0] SAT_LO = -QW'(1 << (SW - 1));

   // configuration
   logic          enabled_ff;
   logic [TW-1:0] taps_ff;
   logic [TW-1:0] taps_eff;
   logic [TW-1:0] taps_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b1;
         taps_ff    <= fir_sat_pkg::TAPS_RESET;
      end else if (csr_we) begin
         if (csr_index == fir_sat_pkg::CSR_ENABLED) begin
            enabled_ff <= csr_wdata[0];
         end
         if (csr_index == fir_sat_pkg::CSR_TAPS) begin
            taps_ff <= TW'(csr_wdata);
         end
      end
   end

   always_comb begin
      if (taps_ff < fir_sat_pkg::TAPS_MIN) begin
         taps_eff = fir_sat_pkg::TAPS_MIN;
      end else if (taps_ff > fir_sat_pkg::TAPS_MAX) begin
         taps_eff = fir_sat_pkg::TAPS_MAX;
      end else begin
         taps_eff = taps_ff;
      end
   end

   assign taps_last = taps_eff - TW'(1);

   // ring position and fill count of the history
   logic [AW-1:0] ring_ff, fill_ff;
   logic [AW-1:0] ring_next;

   assign ring_next = (ring_ff == HIST_LAST) ? '0 : ring_ff + AW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.hist_clear) begin
         ring_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.hist_push) begin
         ring_ff <= ring_next;
         if (fill_ff != FILL_MAX) begin
            fill_ff <= fill_ff + AW'(1);
         end
      end
   end

   // tap walk
   logic signed [SW-1:0] x_ff;
   logic [TW-1:0]        tap_ff;
   logic [AW-1:0]        hidx_ff;
   logic                 hist_ok;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff <= req_sample_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff  <= '0;
         hidx_ff <= '0;
      end else if (cmd.start) begin
         tap_ff  <= '0;
         hidx_ff <= ring_ff;
      end else if (cmd.issue) begin
         tap_ff <= tap_ff + TW'(1);
         if (tap_ff != '0) begin
            hidx_ff <= (hidx_ff == '0) ? HIST_LAST : hidx_ff - AW'(1);
         end
      end
   end

   assign hist_ok = (tap_ff - TW'(1)) < TW'(fill_ff);

   // memories
   logic [CW-1:0] coef_rd;
   logic [SW-1:0] hist_rd;

   fir_sat_ram #(
      .WIDTH (CW),
      .DEPTH (fir_sat_pkg::MAX_TAPS)
   ) u_coef_ram (
      .clock   (clock),
      .wr_en   (cmd.coef_write),
      .wr_addr (req_coef_index),
      .wr_data (req_coef_value),
      .rd_addr (tap_ff[AW-1:0]),
      .rd_data (coef_rd)
   );

   fir_sat_ram #(
      .WIDTH (SW),
      .DEPTH (fir_sat_pkg::HIST_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (cmd.hist_push),
      .wr_addr (ring_next),
      .wr_data (x_ff),
      .rd_addr (hidx_ff),
      .rd_data (hist_rd)
   );

   // multiply-accumulate pipeline
   logic                 a_vld_ff, a_first_ff, a_ok_ff;
   logic                 b_vld_ff;
   logic signed [SW-1:0] operand;
   logic signed [PW-1:0] prod_ff;
   logic signed [ACW-1:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
         b_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= cmd.issue;
         b_vld_ff <= a_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_first_ff <= (tap_ff == '0);
      a_ok_ff    <= hist_ok;
   end

   always_comb begin
      if (a_first_ff) begin
         operand = x_ff;
      end else if (a_ok_ff) begin
         operand = $signed(hist_rd);
      end else begin
         operand = '0;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(coef_rd) * operand;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (b_vld_ff) begin
         acc_ff <= acc_ff + ACW'(prod_ff);
      end
   end

   // round half to even, then saturate
   logic signed [QW-1:0] q_floor, q_ff;
   logic [FB-1:0]        rem;
   logic                 round_up;

   assign q_floor  = QW'(acc_ff >>> FB);
   assign rem      = acc_ff[FB-1:0];
   assign round_up = (rem > {1'b1, {(FB - 1){1'b0}}}) ||
                     ((rem == {1'b1, {(FB - 1){1'b0}}}) && q_floor[0]);

   always_ff @(posedge clock) begin
      if (cmd.round) begin
         q_ff <= q_floor + QW'(round_up);
      end
   end

   // output word
   logic                 rsp_valid_ff;
   logic signed [SW-1:0] sample_out_ff;
   logic                 clipped_ff;
   logic signed [SW-1:0] sat_val;
   logic                 sat_clip;

   always_comb begin
      if (q_ff > SAT_HI) begin
         sat_val  = SW'(SAT_HI);
         sat_clip = 1'b1;
      end else if (q_ff < SAT_LO) begin
         sat_val  = SW'(SAT_LO);
         sat_clip = 1'b1;
      end else begin
         sat_val  = SW'(q_ff);
         sat_clip = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         sample_out_ff <= cmd.pass ? x_ff : sat_val;
         clipped_ff    <= cmd.pass ? 1'b0 : sat_clip;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = sample_out_ff;
   assign rsp_clipped    = clipped_ff;

   assign status.last_tap = (tap_ff == taps_last);
   assign status.enabled  = enabled_ff;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

endmodule

FILE: rtl/fir_filter_saturating_top.sv
// Top level of the saturating direct-form FIR filter.
// Filtered sample: one shared multiply-accumulate per tap; the controller walks the taps,
// drains the MAC pipeline, rounds, then waits until the output register is free. No new
// word is taken until the controller is back in idle, so words are not overlapped.
// Reset clears control, ring position and history fill count; enabled = 1, taps_in_use = 128.
// The coefficient store is undefined until loaded; no clearing pass is run.
module fir_filter_saturating_top (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [fir_sat_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fir_sat_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic signed [fir_sat_pkg::SAMPLE_W-1:0] req_sample_in,
   input  logic [fir_sat_pkg::ADDR_W-1:0]          req_coef_index,
   input  logic signed [fir_sat_pkg::COEF_W-1:0]   req_coef_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [fir_sat_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                    rsp_clipped
);

   fir_sat_pkg::cmd_type    cmd;
   fir_sat_pkg::status_type status;

   fir_sat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_mode),
      .status    (status),
      .cmd       (cmd)
   );

   fir_sat_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_sample_in  (req_sample_in),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .cmd            (cmd),
      .status         (status),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_sample_out (rsp_sample_out),
      .rsp_clipped    (rsp_clipped)
   );

endmodule
